>>> rtl/utf8v_pkg.sv
// utf8v_pkg: shared types and constants for the UTF-8 stream validator.
// Used by utf8v_step and utf8_stream_validator; no dependencies.

package utf8v_pkg;

   // status codes carried on the result channel
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ACCEPTED   = 3'd1;
   localparam logic [2:0] ST_BAD_LEAD   = 3'd2;
   localparam logic [2:0] ST_UNFINISHED = 3'd3;
   localparam logic [2:0] ST_BAD_CONT   = 3'd4;
   localparam logic [2:0] ST_BAD_CP     = 3'd5;

   localparam int unsigned CP_WIDTH     = 21;
   localparam int unsigned ERR_OFF_WIDTH = 32;

   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;

   localparam logic [CP_WIDTH-1:0] CP_MAX      = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] SURR_LO     = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURR_HI     = 21'h00DFFF;
   localparam logic [CP_WIDTH-1:0] MIN_2BYTE   = 21'h000080;
   localparam logic [CP_WIDTH-1:0] MIN_3BYTE   = 21'h000800;
   localparam logic [CP_WIDTH-1:0] MIN_4BYTE   = 21'h010000;

   // sequence tracking state that does not depend on the offset width
   typedef struct packed {
      logic [1:0]          bytes_left;
      logic [1:0]          lead_class;
      logic [CP_WIDTH-1:0] code_accum;
      logic                cont_fault;
      logic [2:0]          sticky_status;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RESET = '{
      bytes_left:    2'd0,
      lead_class:    2'd0,
      code_accum:    '0,
      cont_fault:    1'b0,
      sticky_status: ST_OK
   };

endpackage

>>> rtl/utf8_stream_validator.sv
// utf8_stream_validator: strict UTF-8 checker, one byte in, one status out.
// Depends on utf8v_pkg, utf8v_step and utf8v_out_buf.
//
//  channel   | dir | tdata                        | tuser       | tlast
//  req_      | in  | [7:0] data_byte              | [0] first   | last_byte
//  rsp_      | out | [2:0] status, [34:3] offset  | -           | -
//
// One byte per cycle while the result buffer is not full. The byte lands in an input
// register; from there the combinational decoder update is written into the state
// registers and a two-entry result buffer, and rsp_tvalid comes from that buffer.
// req_tready depends only on registers; it drops when the result buffer is full
// and the input register holds a byte.
// Synchronous active-high reset clears the decoder state and both buffers.

module utf8_stream_validator #(
   parameter int unsigned OFFSET_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [2:0] status, [34:3] error_offset, [39:35] zero
);

   localparam int unsigned RSP_WIDTH = 40;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff;
   logic        in_last_ff;
   logic        req_xfer;
   logic        advance;
   logic        buf_full;

   utf8v_pkg::seq_state_type state_ff, state_in;
   logic [OFFSET_WIDTH-1:0]  seq_start_ff, seq_start_in;
   logic [OFFSET_WIDTH-1:0]  byte_count_ff, byte_count_in;
   logic [OFFSET_WIDTH-1:0]  fault_pos_ff, fault_pos_in;

   logic [utf8v_pkg::ERR_OFF_WIDTH-1:0] fault_pos_sat;
   logic [utf8v_pkg::ERR_OFF_WIDTH-1:0] err_offset;
   logic [RSP_WIDTH-1:0]                rsp_word;

   assign req_xfer    = req_tvalid && req_tready;
   assign advance     = in_valid_ff && !buf_full;
   assign req_tready  = !in_valid_ff || !buf_full;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser[0];
         in_last_ff  <= req_tlast;
      end
   end

   utf8v_step #(
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_step (
      .state               (state_ff),
      .seq_start           (seq_start_ff),
      .byte_count          (byte_count_ff),
      .fault_position      (fault_pos_ff),
      .data_byte           (in_byte_ff),
      .first_byte          (in_first_ff),
      .last_byte           (in_last_ff),
      .state_next          (state_in),
      .seq_start_next      (seq_start_in),
      .byte_count_next     (byte_count_in),
      .fault_position_next (fault_pos_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= utf8v_pkg::SEQ_STATE_RESET;
         seq_start_ff  <= '0;
         byte_count_ff <= '0;
         fault_pos_ff  <= '0;
      end else if (advance) begin
         state_ff      <= state_in;
         seq_start_ff  <= seq_start_in;
         byte_count_ff <= byte_count_in;
         fault_pos_ff  <= fault_pos_in;
      end
   end

   // offsets that do not fit the 32-bit result field saturate
   generate
      if (OFFSET_WIDTH > utf8v_pkg::ERR_OFF_WIDTH) begin : g_sat
         assign fault_pos_sat = (|fault_pos_in[OFFSET_WIDTH-1:utf8v_pkg::ERR_OFF_WIDTH]) ?
                                {utf8v_pkg::ERR_OFF_WIDTH{1'b1}} :
                                fault_pos_in[utf8v_pkg::ERR_OFF_WIDTH-1:0];
      end else begin : g_ext
         assign fault_pos_sat = utf8v_pkg::ERR_OFF_WIDTH'(fault_pos_in);
      end
   endgenerate

   assign err_offset = (state_in.sticky_status >= utf8v_pkg::ST_BAD_LEAD) ?
                       fault_pos_sat : '0;
   assign rsp_word   = {5'd0, err_offset, state_in.sticky_status};

   utf8v_out_buf #(
      .DATA_WIDTH(RSP_WIDTH)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (rsp_word),
      .full      (buf_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

>>> rtl/utf8v_step.sv
// utf8v_step: combinational per-byte update of the UTF-8 decoder state.
// Uses utf8v_pkg for state type, status codes and byte-class bounds.

module utf8v_step #(
   parameter int unsigned OFFSET_WIDTH = 32
) (
   input  utf8v_pkg::seq_state_type    state,
   input  logic [OFFSET_WIDTH-1:0]     seq_start,
   input  logic [OFFSET_WIDTH-1:0]     byte_count,
   input  logic [OFFSET_WIDTH-1:0]     fault_position,
   input  logic [7:0]                  data_byte,
   input  logic                        first_byte,
   input  logic                        last_byte,
   output utf8v_pkg::seq_state_type    state_next,
   output logic [OFFSET_WIDTH-1:0]     seq_start_next,
   output logic [OFFSET_WIDTH-1:0]     byte_count_next,
   output logic [OFFSET_WIDTH-1:0]     fault_position_next
);

   utf8v_pkg::seq_state_type cur;
   logic [OFFSET_WIDTH-1:0]  cur_start;
   logic [OFFSET_WIDTH-1:0]  cur_count;
   logic [OFFSET_WIDTH-1:0]  cur_fault;
   logic [utf8v_pkg::CP_WIDTH-1:0] cp_min;
   logic [utf8v_pkg::CP_WIDTH-1:0] acc_shift;
   logic                     cp_bad;

   // start mark clears everything before the byte is taken
   always_comb begin
      if (first_byte) begin
         cur       = utf8v_pkg::SEQ_STATE_RESET;
         cur_start = '0;
         cur_count = '0;
         cur_fault = '0;
      end else begin
         cur       = state;
         cur_start = seq_start;
         cur_count = byte_count;
         cur_fault = fault_position;
      end
   end

   assign acc_shift = {cur.code_accum[utf8v_pkg::CP_WIDTH-7:0], data_byte[5:0]};

   always_comb begin
      case (cur.lead_class)
         2'd1:    cp_min = utf8v_pkg::MIN_2BYTE;
         2'd2:    cp_min = utf8v_pkg::MIN_3BYTE;
         default: cp_min = utf8v_pkg::MIN_4BYTE;
      endcase
   end

   assign cp_bad = (acc_shift < cp_min) || (acc_shift > utf8v_pkg::CP_MAX) ||
                   ((acc_shift >= utf8v_pkg::SURR_LO) && (acc_shift <= utf8v_pkg::SURR_HI));

   always_comb begin
      state_next          = cur;
      seq_start_next      = cur_start;
      byte_count_next     = cur_count;
      fault_position_next = cur_fault;

      // after a verdict, bytes are ignored until the next start mark
      if (cur.sticky_status == utf8v_pkg::ST_OK) begin
         if (cur_count != {OFFSET_WIDTH{1'b1}}) begin
            byte_count_next = cur_count + 1'b1;
         end

         if (cur.bytes_left == 2'd0) begin
            seq_start_next       = cur_count;
            state_next.cont_fault = 1'b0;
            if (!data_byte[7]) begin
               // ASCII, nothing to open
            end else if (data_byte >= utf8v_pkg::LEAD2_LO &&
                         data_byte <= utf8v_pkg::LEAD2_HI) begin
               state_next.lead_class = 2'd1;
               state_next.bytes_left = 2'd1;
               state_next.code_accum = {16'd0, data_byte[4:0]};
            end else if (data_byte >= utf8v_pkg::LEAD3_LO &&
                         data_byte <= utf8v_pkg::LEAD3_HI) begin
               state_next.lead_class = 2'd2;
               state_next.bytes_left = 2'd2;
               state_next.code_accum = {17'd0, data_byte[3:0]};
            end else if (data_byte >= utf8v_pkg::LEAD4_LO &&
                         data_byte <= utf8v_pkg::LEAD4_HI) begin
               state_next.lead_class = 2'd3;
               state_next.bytes_left = 2'd3;
               state_next.code_accum = {18'd0, data_byte[2:0]};
            end else begin
               state_next.sticky_status = utf8v_pkg::ST_BAD_LEAD;
               fault_position_next      = cur_count;
            end
         end else begin
            if ((data_byte & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_TAG) begin
               state_next.cont_fault = 1'b1;
            end
            state_next.code_accum = acc_shift;
            state_next.bytes_left = cur.bytes_left - 2'd1;
            // a bad continuation is reported only once its sequence is complete
            if (cur.bytes_left == 2'd1) begin
               if (state_next.cont_fault) begin
                  state_next.sticky_status = utf8v_pkg::ST_BAD_CONT;
                  fault_position_next      = cur_start;
               end else if (cp_bad) begin
                  state_next.sticky_status = utf8v_pkg::ST_BAD_CP;
                  fault_position_next      = cur_start;
               end
            end
         end

         if (last_byte && state_next.sticky_status == utf8v_pkg::ST_OK) begin
            if (state_next.bytes_left != 2'd0) begin
               state_next.sticky_status = utf8v_pkg::ST_UNFINISHED;
               fault_position_next      = seq_start_next;
            end else begin
               state_next.sticky_status = utf8v_pkg::ST_ACCEPTED;
            end
         end
      end
   end

endmodule

>>> rtl/utf8v_out_buf.sv
// utf8v_out_buf: two-entry result buffer; its ready comes straight from a register.
// No package dependencies.

module utf8v_out_buf #(
   parameter int unsigned DATA_WIDTH = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_data
);

   logic [DATA_WIDTH-1:0] entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = count_ff != 2'd0;
   assign full      = count_ff == 2'd2;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> tb/tb_utf8_stream_validator.sv
// tb_utf8_stream_validator: self-checking bench for the UTF-8 stream validator.
// Drives bytes with start/end marks, predicts status and error offset per byte.
// Depends on utf8v_pkg and utf8_stream_validator.

module tb_utf8_stream_validator;

   localparam int IDLE_LIMIT = 2000;

   typedef struct {
      logic [7:0] data;
      bit         first;
      bit         last;
      bit         drain;   // hold this byte until every result is back
   } byte_item_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] offset;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic [0:0]  req_tuser = '0;   // [0] first_byte
   logic        req_tlast = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [2:0] status, [34:3] error_offset, [39:35] zero

   byte_item_type byte_feed[$];
   verdict_type   expected_verdicts[$];
   byte_item_type cur_item;
   verdict_type   want;
   bit         on_bus;
   int         send_wait, hold_wait, calm_req, calm_rsp;
   int         sent_count, checked_count, fail_count, idle_cycles;

   // predictor state
   logic [1:0]  cont_due;
   logic [1:0]  seq_class;
   logic [20:0] cp_accum;
   logic [31:0] lead_offset;
   logic [31:0] next_offset;
   bit          cont_bad;
   logic [2:0]  run_status;
   logic [31:0] fault_offset;

   utf8_stream_validator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
      return $urandom_range(0, 4);
   endfunction

   task automatic push_item(input logic [7:0] d, input bit f, input bit l,
                            input bit drain = 1'b0);
      byte_item_type it;
      it.data = d;
      it.first = f;
      it.last = l;
      it.drain = drain;
      byte_feed.insert(byte_feed.size(), it);
   endtask

   task automatic clear_decoder();
      cont_due = '0;
      seq_class = '0;
      cp_accum = '0;
      lead_offset = '0;
      next_offset = '0;
      cont_bad = 1'b0;
      run_status = utf8v_pkg::ST_OK;
      fault_offset = '0;
   endtask

   // Advances the decoder by one byte and queues the status it must report.
   task automatic track_utf8(input logic [7:0] b, input bit first, input bit last);
      verdict_type v;
      logic [31:0] pos;
      logic [20:0] floor_cp;
      if (first) clear_decoder();
      if (run_status == utf8v_pkg::ST_OK) begin
         pos = next_offset;
         if (next_offset != '1) next_offset++;
         if (cont_due == 0) begin
            lead_offset = pos;
            cont_bad = 1'b0;
            if (!b[7]) begin
               // plain ASCII
            end else if (b >= utf8v_pkg::LEAD2_LO && b <= utf8v_pkg::LEAD2_HI) begin
               seq_class = 2'd1; cont_due = 2'd1; cp_accum = {16'd0, b[4:0]};
            end else if (b >= utf8v_pkg::LEAD3_LO && b <= utf8v_pkg::LEAD3_HI) begin
               seq_class = 2'd2; cont_due = 2'd2; cp_accum = {17'd0, b[3:0]};
            end else if (b >= utf8v_pkg::LEAD4_LO && b <= utf8v_pkg::LEAD4_HI) begin
               seq_class = 2'd3; cont_due = 2'd3; cp_accum = {18'd0, b[2:0]};
            end else begin
               run_status = utf8v_pkg::ST_BAD_LEAD;
               fault_offset = pos;
            end
         end else begin
            if ((b & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_TAG) cont_bad = 1'b1;
            cp_accum = {cp_accum[14:0], b[5:0]};
            cont_due--;
            if (cont_due == 0) begin
               floor_cp = (seq_class == 2'd1) ? utf8v_pkg::MIN_2BYTE :
                          (seq_class == 2'd2) ? utf8v_pkg::MIN_3BYTE : utf8v_pkg::MIN_4BYTE;
               // a bad continuation wins over the code point checks
               if (cont_bad) begin
                  run_status = utf8v_pkg::ST_BAD_CONT;
                  fault_offset = lead_offset;
               end else if (cp_accum < floor_cp || cp_accum > utf8v_pkg::CP_MAX ||
                            (cp_accum >= utf8v_pkg::SURR_LO &&
                             cp_accum <= utf8v_pkg::SURR_HI)) begin
                  run_status = utf8v_pkg::ST_BAD_CP;
                  fault_offset = lead_offset;
               end
            end
         end
         if (last && run_status == utf8v_pkg::ST_OK) begin
            if (cont_due != 0) begin
               run_status = utf8v_pkg::ST_UNFINISHED;
               fault_offset = lead_offset;
            end else begin
               run_status = utf8v_pkg::ST_ACCEPTED;
            end
         end
      end
      v.status = run_status;
      v.offset = (run_status >= utf8v_pkg::ST_BAD_LEAD) ? fault_offset : '0;
      expected_verdicts.insert(expected_verdicts.size(), v);
   endtask

   initial clear_decoder();

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         on_bus = 1'b0;
         send_wait = 0;
         sent_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_utf8(req_tdata, req_tuser[0], req_tlast);
            sent_count++;
            on_bus = 1'b0;
         end
         if (!on_bus) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (byte_feed.size() != 0 &&
                         (!byte_feed[0].drain || checked_count == sent_count)) begin
               cur_item = byte_feed.pop_front();
               req_tdata <= cur_item.data;
               req_tuser <= cur_item.first;
               req_tlast <= cur_item.last;
               on_bus = 1'b1;
               send_wait = draw_wait(calm_req);
            end
         end
         req_tvalid <= on_bus;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_wait = 0;
         checked_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result transfer, tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata[2:0] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[2:0]);
                  fail_count++;
               end
               if (rsp_tdata[34:3] !== want.offset) begin
                  $error("error_offset: expected %0d, actual %0d", want.offset,
                         rsp_tdata[34:3]);
                  fail_count++;
               end
               if (rsp_tdata[39:35] !== 5'd0) begin
                  $error("pad: expected 0, actual %h", rsp_tdata[39:35]);
                  fail_count++;
               end
            end
            checked_count <= checked_count + 1;
            hold_wait = draw_wait(calm_rsp);
         end
         if (hold_wait > 0) begin
            hold_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: no transfer on either side for too long
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit [7:0]  chunk[$];
      bit [7:0]  enc[4];
      bit [7:0]  junk;
      bit [20:0] cp;
      bit        with_end;
      int        n_chars, flaw_at, flaw, len, k, random_items;

      // no start mark after reset: the stream counts from reset
      push_item(8'h41, 0, 0);
      push_item(8'h00, 0, 0);
      push_item(8'hC2, 0, 0);  // U+0080, smallest two-byte form
      push_item(8'h80, 0, 0);
      push_item(8'h7F, 0, 1);
      push_item(8'h00, 1, 1);  // start and end on one byte
      // bad lead at offset 1; later bytes without a start mark are ignored
      push_item(8'h41, 1, 0);
      push_item(8'hF5, 0, 0);
      push_item(8'hFF, 0, 0);
      push_item(8'hE0, 1, 0);  // overlong three-byte form
      push_item(8'h80, 0, 0);
      push_item(8'h80, 0, 1);
      push_item(8'hED, 1, 0);  // surrogate
      push_item(8'hA0, 0, 0);
      push_item(8'h80, 0, 0);
      push_item(8'hF4, 1, 0);  // U+10FFFF, highest code point
      push_item(8'h8F, 0, 0);
      push_item(8'hBF, 0, 0);
      push_item(8'hBF, 0, 1);
      push_item(8'hF4, 1, 0);  // just above U+10FFFF
      push_item(8'h90, 0, 0);
      push_item(8'h80, 0, 0);
      push_item(8'h80, 0, 0);
      // cut short with a bad continuation inside: unfinished wins
      push_item(8'hF0, 1, 0);
      push_item(8'h41, 0, 0);
      push_item(8'h80, 0, 1);
      push_item(8'hDF, 1, 0);  // bad continuation on a completed sequence
      push_item(8'hC0, 0, 1);

      random_items = 0;
      while (random_items < 1500) begin
         chunk.delete();
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8))
               chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
         end else begin
            n_chars = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 70)
                                                   : $urandom_range(1, 10);
            flaw_at = ($urandom_range(0, 4) < 2) ? $urandom_range(0, n_chars - 1) : -1;
            for (int c = 0; c < n_chars; c++) begin
               flaw = (c == flaw_at) ? $urandom_range(1, 5) : 0;
               case ($urandom_range(0, 3))
                  0: begin cp = 21'($urandom_range(0, 'h7F)); len = 1; end
                  1: begin cp = 21'($urandom_range('h80, 'h7FF)); len = 2; end
                  2: begin cp = 21'($urandom_range('h800, 'hFFFF)); len = 3; end
                  default: begin cp = 21'($urandom_range('h10000, 'h10FFFF)); len = 4; end
               endcase
               if (flaw == 1) begin
                  // overlong, or out of range for the longest form
                  if (len < 4) len++;
                  else cp = 21'($urandom_range('h110000, 'h1FFFFF));
               end else if (flaw == 2) begin
                  cp = 21'($urandom_range('hD800, 'hDFFF));
                  len = 3;
               end
               case (len)
                  1: enc[0] = {1'b0, cp[6:0]};
                  2: begin
                     enc[0] = {3'b110, cp[10:6]};
                     enc[1] = {2'b10, cp[5:0]};
                  end
                  3: begin
                     enc[0] = {4'b1110, cp[15:12]};
                     enc[1] = {2'b10, cp[11:6]};
                     enc[2] = {2'b10, cp[5:0]};
                  end
                  default: begin
                     enc[0] = {5'b11110, cp[20:18]};
                     enc[1] = {2'b10, cp[17:12]};
                     enc[2] = {2'b10, cp[11:6]};
                     enc[3] = {2'b10, cp[5:0]};
                  end
               endcase
               if (flaw == 3 && len > 1) begin
                  // any byte outside 10xxxxxx
                  junk = 8'($urandom_range(0, 255));
                  if (!junk[6]) junk[7] = 1'b0;
                  enc[$urandom_range(1, len - 1)] = junk;
               end else if (flaw == 4) begin
                  enc[0] = 8'($urandom_range(8'h80, 8'hFF));
               end else if (flaw == 5 && len > 1) begin
                  len = $urandom_range(1, len - 1);
               end
               for (k = 0; k < len; k++) chunk.insert(chunk.size(), enc[k]);
            end
         end
         with_end = ($urandom_range(0, 9) != 0);
         foreach (chunk[i])
            push_item(chunk[i], i == 0, with_end && i == chunk.size() - 1,
                      i == 0 && (random_items == 0 || $urandom_range(0, 49) == 0));
         random_items += chunk.size();
         // trailing bytes after a verdict, without a start mark
         if (with_end && $urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) push_item(8'($urandom_range(0, 255)), 0, 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (byte_feed.size() != 0 || on_bus || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
